// ===== design/ansi_text_console_renderer_macros.svh =====
// Assertion macros shared by the console renderer RTL.
`ifndef ANSI_TEXT_CONSOLE_RENDERER_MACROS_SVH
`define ANSI_TEXT_CONSOLE_RENDERER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property outside of reset.
`define ATCR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("atcr: assertion failed");
// Check a property at every edge, reset included.
`define ATCR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("atcr: assertion failed around reset");
`else
`define ATCR_ASSERT(label, prop)
`define ATCR_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== design/atcr_pkg.sv =====
`timescale 1ns / 1ps
package atcr_pkg;

  // Default geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 24;

  // Fixed field widths
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int WORD_W  = 16;
  localparam int COLOR_W = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Attribute values
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;
  localparam logic [COLOR_W-1:0] COLOR_BRIGHT = 8'h0f;
  localparam logic [COLOR_W-1:0] COLOR_INVERT = 8'h70;

  // Escape parser phases
  localparam logic [2:0] PH_NONE    = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_BRACKET = 3'd2;
  localparam logic [2:0] PH_PARAM   = 3'd3;
  localparam logic [2:0] PH_COLOR   = 3'd4;

  // Character codes
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_4      = 8'h34;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_J      = 8'h4a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_M      = 8'h6d;

  // ANSI color digit to attribute nibble
  localparam logic [3:0] PALETTE [8] = '{4'd0, 4'd4, 4'd2, 4'd14, 4'd1, 4'd5, 4'd3, 4'd15};

  // Cursor movement requested by one put
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_CR,
    CUR_LF,
    CUR_TAB,
    CUR_BS,
    CUR_ADV
  } cur_op_t;

  // Decoder result for one put
  typedef struct packed {
    logic [2:0]         phase_next;
    logic [7:0]         kind_next;
    logic [3:0]         pend_next;
    logic [COLOR_W-1:0] color_next;
    cur_op_t            cur_op;
    logic               write_char;
    logic               clear_screen;
  } esc_result_t;

endpackage

// ===== design/atcr_esc_decode.sv =====
`timescale 1ns / 1ps
module atcr_esc_decode (
  input  logic [7:0]                  ch,
  input  logic [2:0]                  phase,
  input  logic [7:0]                  kind,
  input  logic [3:0]                  pend,
  input  logic [atcr_pkg::COLOR_W-1:0] color,
  output atcr_pkg::esc_result_t       res
);
  import atcr_pkg::*;

  logic consumed;

  // Advance the escape parser, fall back to control or printable handling
  always_comb begin
    res.phase_next   = phase;
    res.kind_next    = kind;
    res.pend_next    = pend;
    res.color_next   = color;
    res.cur_op       = CUR_HOLD;
    res.write_char   = 1'b0;
    res.clear_screen = 1'b0;
    consumed         = 1'b0;

    case (phase)
      PH_ESC: begin
        if (ch == CH_LBRACK) begin
          res.phase_next = PH_BRACKET;
          consumed       = 1'b1;
        end
      end
      PH_BRACKET: begin
        if (ch inside {CH_0, CH_1, CH_2, CH_3, CH_4, CH_7}) begin
          res.phase_next = PH_PARAM;
          res.kind_next  = ch;
          consumed       = 1'b1;
        end
      end
      PH_PARAM: begin
        if (ch inside {[CH_0:CH_7]}) begin
          if (kind == CH_3 || kind == CH_4) begin
            res.pend_next  = PALETTE[ch[2:0]];
            res.phase_next = PH_COLOR;
            consumed       = 1'b1;
          end
        end else if (ch == CH_J) begin
          if (kind == CH_2) begin
            res.clear_screen = 1'b1;
            res.cur_op       = CUR_HOME;
            res.phase_next   = PH_NONE;
            consumed         = 1'b1;
          end
        end else if (ch == CH_M) begin
          if (kind == CH_0) begin
            res.color_next = COLOR_RESET;
            res.phase_next = PH_NONE;
            consumed       = 1'b1;
          end else if (kind == CH_1) begin
            res.color_next = COLOR_BRIGHT;
            res.phase_next = PH_NONE;
            consumed       = 1'b1;
          end else if (kind == CH_7) begin
            res.color_next = COLOR_INVERT;
            res.phase_next = PH_NONE;
            consumed       = 1'b1;
          end
        end
      end
      PH_COLOR: begin
        if (ch == CH_M && kind == CH_3) begin
          res.color_next = {color[7:4], pend};
          res.phase_next = PH_NONE;
          consumed       = 1'b1;
        end else if (ch == CH_M && kind == CH_4) begin
          res.color_next = {pend, color[3:0]};
          res.phase_next = PH_NONE;
          consumed       = 1'b1;
        end
      end
      default: ;
    endcase

    // Handle the byte as a normal character when the parser did not take it
    if (!consumed) begin
      if (ch == CH_ESC) begin
        res.phase_next = PH_ESC;
      end else begin
        res.phase_next = PH_NONE;
        case (ch)
          CH_CR:   res.cur_op = CUR_CR;
          CH_LF:   res.cur_op = CUR_LF;
          CH_TAB:  res.cur_op = CUR_TAB;
          CH_BS:   res.cur_op = CUR_BS;
          default: begin
            res.cur_op     = CUR_ADV;
            res.write_char = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

// ===== design/ansi_text_console_renderer.sv =====
`timescale 1ns / 1ps
// A put result goes out from ST_RESULT; a read result goes through ST_READ, then ST_RESULT.
// Only one item is taken at a time, in ST_IDLE; a scroll copies the rows up at one word per cycle
// through the single-port read, then clears the bottom row.
// ESC[2J fills the store with spaces in the current color, one word per cycle.
// Reset (rst, synchronous): clears the store, no input taken meanwhile.
// The result register frees the input side: a new item is taken while a result waits.
`include "ansi_text_console_renderer_macros.svh"
module ansi_text_console_renderer #(
  parameter int COLUMNS = atcr_pkg::COLUMNS_DEF,
  parameter int ROWS    = atcr_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [atcr_pkg::IN_TDATA_W-1:0]   s_tdata,  // char_code[7:0], cell_index[18:8], zero fill
  input  logic [0:0]                        s_tuser,  // mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [atcr_pkg::OUT_TDATA_W-1:0]  m_tdata   // read_cell[15:0], cursor_now[26:16],
                                                      // color_now[34:27], in_escape[35], zero fill
);
  import atcr_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 4);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int CSW   = $clog2(COLUMNS + 4);

  typedef enum logic [4:0] {
    ST_FILL   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_COPY   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  // Input fields
  logic               mode;
  logic [CHAR_W-1:0]  char_code;
  logic [INDEX_W-1:0] cell_index;
  logic               accept;

  // Console state
  state_t             state;
  logic [CW-1:0]      cursor;
  logic [CLW-1:0]     col;
  logic [COLOR_W-1:0] color;
  logic [3:0]         pend;
  logic [2:0]         phase;
  logic [7:0]         kind;

  assign mode       = s_tuser[0];
  assign char_code  = s_tdata[CHAR_W-1:0];
  assign cell_index = s_tdata[CHAR_W+INDEX_W-1:CHAR_W];
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;

  // Sweep control
  logic [AW-1:0]      fill_addr;
  logic [WORD_W-1:0]  fill_val;
  logic               fill_reply;
  logic [AW-1:0]      copy_src;
  logic               copy_issued;
  logic               copy_wr_valid;
  logic [AW-1:0]      copy_wr_addr;
  logic [WORD_W-1:0]  read_word;
  logic               read_oor;

  // Screen store
  logic [WORD_W-1:0]  mem [CELLS];
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [WORD_W-1:0]  mem_wd;
  logic [AW-1:0]      mem_ra;
  logic [WORD_W-1:0]  rd_data;

  esc_result_t        esc;

  atcr_esc_decode u_esc (
    .ch    (char_code),
    .phase (phase),
    .kind  (kind),
    .pend  (pend),
    .color (color),
    .res   (esc)
  );

  // Cursor movement for one put
  logic [CW-1:0]  cur_n;
  logic [CW-1:0]  cur_fin;
  logic [CLW-1:0] col_n;
  logic [2:0]     tab_step;
  logic [CSW-1:0] col_sum;
  logic           scroll;

  always_comb begin
    cur_n    = cursor;
    col_n    = col;
    tab_step = 3'd4 - {1'b0, cursor[1:0]};
    col_sum  = CSW'(col) + CSW'(tab_step);
    case (esc.cur_op)
      CUR_HOME: begin
        cur_n = '0;
        col_n = '0;
      end
      CUR_CR: begin
        cur_n = cursor - CW'(col);
        col_n = '0;
      end
      CUR_LF: begin
        cur_n = cursor + CW'(COLUMNS) - CW'(col);
        col_n = '0;
      end
      CUR_TAB: begin
        cur_n = cursor + CW'(tab_step);
        col_n = (col_sum >= CSW'(COLUMNS)) ? CLW'(col_sum - CSW'(COLUMNS)) : CLW'(col_sum);
      end
      CUR_BS: begin
        if (cursor != '0) begin
          cur_n = cursor - CW'(1);
          col_n = (col == '0) ? CLW'(COLUMNS - 1) : col - CLW'(1);
        end
      end
      CUR_ADV: begin
        cur_n = cursor + CW'(1);
        col_n = (col == CLW'(COLUMNS - 1)) ? '0 : col + CLW'(1);
      end
      default: ;
    endcase
    scroll  = (cur_n >= CW'(CELLS));
    cur_fin = scroll ? cur_n - CW'(COLUMNS) : cur_n;
  end

  // Select the store port per state
  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill_addr;
    mem_wd = fill_val;
    mem_ra = copy_src;
    case (state)
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_ra = AW'(cell_index);
        mem_we = accept && !mode && esc.write_char;
        mem_wa = AW'(cursor);
        mem_wd = {color, char_code};
      end
      ST_COPY: begin
        mem_we = copy_wr_valid;
        mem_wa = copy_wr_addr;
        mem_wd = rd_data;
      end
      default: ;
    endcase
  end

  // Write and read the store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  // Sequence items, sweeps and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FILL;
      cursor        <= '0;
      col           <= '0;
      color         <= COLOR_RESET;
      pend          <= '0;
      phase         <= PH_NONE;
      kind          <= '0;
      fill_addr     <= '0;
      fill_val      <= '0;
      fill_reply    <= 1'b0;
      copy_issued   <= 1'b0;
      copy_wr_valid <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one goes out in its place
      if (m_tvalid && m_tready && state != ST_RESULT) m_tvalid <= 1'b0;

      case (state)
        ST_FILL: begin
          if (fill_addr == AW'(CELLS - 1)) begin
            state <= fill_reply ? ST_RESULT : ST_IDLE;
          end else begin
            fill_addr <= fill_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (mode) begin
              read_oor <= (32'(cell_index) >= 32'(CELLS));
              state    <= ST_READ;
            end else begin
              read_word <= '0;
              cursor    <= cur_fin;
              col       <= col_n;
              color     <= esc.color_next;
              pend      <= esc.pend_next;
              phase     <= esc.phase_next;
              kind      <= esc.kind_next;
              if (esc.clear_screen) begin
                fill_addr  <= '0;
                fill_val   <= {color, CH_SPACE};
                fill_reply <= 1'b1;
                state      <= ST_FILL;
              end else if (scroll) begin
                copy_src      <= AW'(COLUMNS);
                copy_issued   <= 1'b0;
                copy_wr_valid <= 1'b0;
                state         <= ST_COPY;
              end else begin
                state <= ST_RESULT;
              end
            end
          end
        end
        ST_READ: begin
          read_word <= read_oor ? '0 : rd_data;
          state     <= ST_RESULT;
        end
        ST_COPY: begin
          // Read one row ahead, write the word back one row up
          copy_wr_valid <= !copy_issued;
          copy_wr_addr  <= copy_src - AW'(COLUMNS);
          if (!copy_issued) begin
            if (copy_src == AW'(CELLS - 1)) copy_issued <= 1'b1;
            else copy_src <= copy_src + AW'(1);
          end
          if (copy_issued && copy_wr_valid) begin
            fill_addr  <= AW'(CELLS - COLUMNS);
            fill_val   <= '0;
            fill_reply <= 1'b1;
            read_word  <= '0;
            state      <= ST_FILL;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, (phase != PH_NONE), color, INDEX_W'(cursor), read_word};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ATCR_ASSERT(a_cursor_in_store, cursor < CW'(CELLS))
  `ATCR_ASSERT(a_col_in_row, int'(col) < COLUMNS)
  `ATCR_ASSERT(a_copy_below_bottom, copy_wr_valid |-> (copy_wr_addr < AW'(CELLS - COLUMNS)))
  `ATCR_ASSERT(a_one_item_at_a_time, accept |=> !s_tready)
  `ATCR_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !m_tvalid)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import atcr_pkg::*;

  localparam int COLS           = COLUMNS_DEF;
  localparam int CELLS          = COLUMNS_DEF * ROWS_DEF;
  localparam int TAB_STOP       = 4;
  localparam bit MODE_PUT       = 1'b0;
  localparam bit MODE_READ      = 1'b1;
  localparam int RANDOM_END     = 600;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 50;
  localparam int WATCHDOG_LIMIT = 20000;

  // Expected status of one result transfer
  typedef struct {
    logic [WORD_W-1:0]  cell_word;
    logic [INDEX_W-1:0] cursor;
    logic [COLOR_W-1:0] color;
    logic               escaping;
  } console_status_t;

  // Shadow of the console: screen store, cursor, attribute and escape parser
  class screen_tracker;
    logic [WORD_W-1:0]  cells [CELLS];
    int                 cursor;
    logic [COLOR_W-1:0] color;
    logic [3:0]         pend;
    logic [2:0]         phase;
    logic [7:0]         kind;
    console_status_t    due_status [$];
    int mismatches, checked, puts, reads, scrolls, clears;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cursor = 0;
      color = COLOR_RESET;
      pend = '0;
      phase = PH_NONE;
      kind = '0;
      mismatches = 0;
      checked = 0;
      puts = 0;
      reads = 0;
      scrolls = 0;
      clears = 0;
    endfunction

    // Advance the shadow by one accepted transfer and queue its status
    function void take_item(logic rd, logic [7:0] ch, logic [INDEX_W-1:0] idx);
      console_status_t s;
      bit consumed;
      s.cell_word = '0;
      consumed = 1'b0;
      if (rd) begin
        reads++;
        if (idx < CELLS) s.cell_word = cells[idx];
      end else begin
        puts++;
        // escape parser gets the first look at the byte
        case (phase)
          PH_ESC: begin
            if (ch == CH_LBRACK) begin
              phase = PH_BRACKET;
              consumed = 1'b1;
            end
          end
          PH_BRACKET: begin
            if (ch == CH_0 || ch == CH_1 || ch == CH_2 || ch == CH_3 || ch == CH_4 ||
                ch == CH_7) begin
              phase = PH_PARAM;
              kind = ch;
              consumed = 1'b1;
            end
          end
          PH_PARAM: begin
            if (ch >= CH_0 && ch <= CH_7) begin
              if (kind == CH_3 || kind == CH_4) begin
                pend = PALETTE[ch[2:0]];
                phase = PH_COLOR;
                consumed = 1'b1;
              end
            end else if (ch == CH_J) begin
              if (kind == CH_2) begin
                foreach (cells[i]) cells[i] = {color, CH_SPACE};
                cursor = 0;
                phase = PH_NONE;
                consumed = 1'b1;
                clears++;
              end
            end else if (ch == CH_M) begin
              if (kind == CH_0 || kind == CH_1 || kind == CH_7) begin
                color = (kind == CH_0) ? COLOR_RESET :
                        (kind == CH_1) ? COLOR_BRIGHT : COLOR_INVERT;
                phase = PH_NONE;
                consumed = 1'b1;
              end
            end
          end
          PH_COLOR: begin
            if (ch == CH_M && kind == CH_3) begin
              color = {color[7:4], pend};
              phase = PH_NONE;
              consumed = 1'b1;
            end else if (ch == CH_M && kind == CH_4) begin
              color = {pend, color[3:0]};
              phase = PH_NONE;
              consumed = 1'b1;
            end
          end
          default: ;
        endcase

        // not part of a sequence: control or printable byte
        if (!consumed) begin
          if (ch == CH_ESC) begin
            phase = PH_ESC;
          end else begin
            if (ch == CH_CR) begin
              cursor -= cursor % COLS;
            end else if (ch == CH_LF) begin
              cursor += COLS - cursor % COLS;
            end else if (ch == CH_TAB) begin
              cursor += TAB_STOP - cursor % TAB_STOP;
            end else if (ch == CH_BS) begin
              if (cursor > 0) cursor--;
            end else begin
              if (cursor < CELLS) cells[cursor] = {color, ch};
              cursor++;
            end
            phase = PH_NONE;
            // scroll up one row and blank the bottom row
            if (cursor >= CELLS) begin
              for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
              for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = '0;
              cursor -= COLS;
              if (cursor >= CELLS) cursor = CELLS - 1;
              scrolls++;
            end
          end
        end
      end
      s.cursor = cursor[INDEX_W-1:0];
      s.color = color;
      s.escaping = (phase != PH_NONE);
      due_status.push_back(s);
    endfunction

    task flag_mismatch(string what, int got, int want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // Compare one result transfer with the oldest expected status
    task check_status(logic [OUT_TDATA_W-1:0] word);
      console_status_t want;
      if (due_status.size() == 0) begin
        flag_mismatch("result with nothing pending, cursor_now", int'(word[26:16]), -1);
      end else begin
        want = due_status.pop_front();
        checked++;
        if (word[15:0] != want.cell_word)
          flag_mismatch("read_cell", int'(word[15:0]), int'(want.cell_word));
        if (word[26:16] != want.cursor)
          flag_mismatch("cursor_now", int'(word[26:16]), int'(want.cursor));
        if (word[34:27] != want.color)
          flag_mismatch("color_now", int'(word[34:27]), int'(want.color));
        if (word[35] != want.escaping)
          flag_mismatch("in_escape", int'(word[35]), int'(want.escaping));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  screen_tracker tracker;
  int items_sent = 0;
  int taken_count = 0;
  bit steady = 1'b0;

  ansi_text_console_renderer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Track accepted inputs and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tracker.take_item(s_tuser[0], s_tdata[7:0], s_tdata[18:8]);
        taken_count++;
      end
      if (m_tvalid && m_tready) tracker.check_status(m_tdata);
    end
  end

  // Drive ready at random, with one long hold-off to back up the block
  initial begin : ready_driver
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && taken_count >= HOLD_AT) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 35);
      end
    end
  end

  // End the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("** ansi_text_console_renderer: FAILED **");
    $finish;
  end

  // Offer one item after an optional gap; hold it until the transfer
  task automatic send_item(input bit rd, input int value);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 35) gap = $urandom_range(3, 1);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata <= IN_TDATA_W'($urandom);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= rd;
    // zero fill above cell_index
    if (rd) s_tdata <= {5'b0, INDEX_W'(value), 8'($urandom)};
    else s_tdata <= {5'b0, INDEX_W'($urandom), 8'(value)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Send one attribute or clear sequence, optionally cut short by a stray byte
  task automatic send_sequence(input bit broken);
    logic [7:0] seq [$];
    int pick, cut;
    seq.push_back(CH_ESC);
    seq.push_back(CH_LBRACK);
    pick = $urandom_range(19);
    if (pick == 0) begin
      seq.push_back(CH_2);
      seq.push_back(CH_J);
    end else if (pick < 7) begin
      seq.push_back(pick < 3 ? CH_0 : (pick < 5 ? CH_1 : CH_7));
      seq.push_back(CH_M);
    end else begin
      seq.push_back(pick < 13 ? CH_3 : CH_4);
      seq.push_back(8'(CH_0 + $urandom_range(7)));
      seq.push_back(CH_M);
    end
    if (broken) begin
      cut = $urandom_range(seq.size() - 1, 1);
      while (seq.size() > cut) void'(seq.pop_back());
      seq.push_back(8'($urandom));
    end
    foreach (seq[i]) send_item(MODE_PUT, seq[i]);
  endtask

  initial begin
    int roll, pick;
    tracker = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, controls, escapes, mismatch, out-of-range read
    send_item(MODE_PUT, 8'h41);
    send_item(MODE_PUT, 8'hff);
    send_item(MODE_PUT, 8'h00);
    send_item(MODE_PUT, CH_TAB);
    send_item(MODE_PUT, CH_BS);
    send_item(MODE_PUT, CH_CR);
    send_item(MODE_PUT, CH_LF);
    send_item(MODE_PUT, CH_ESC);
    send_item(MODE_PUT, CH_LBRACK);
    send_item(MODE_PUT, CH_3);
    send_item(MODE_PUT, CH_1);
    send_item(MODE_PUT, CH_M);
    send_item(MODE_PUT, CH_ESC);
    send_item(MODE_PUT, 8'h78);
    send_item(MODE_READ, 0);
    send_item(MODE_READ, 2047);
    send_item(MODE_PUT, CH_ESC);
    send_item(MODE_PUT, CH_LBRACK);
    send_item(MODE_PUT, CH_7);
    send_item(MODE_PUT, CH_M);
    send_item(MODE_PUT, CH_ESC);
    send_item(MODE_PUT, CH_LBRACK);
    send_item(MODE_PUT, CH_2);
    send_item(MODE_PUT, CH_J);
    // backspace at home saturates
    send_item(MODE_PUT, CH_BS);

    // random mix of text, controls, reads and escape sequences
    while (items_sent < RANDOM_END) begin
      steady = (items_sent >= 300 && items_sent < 420);
      roll = $urandom_range(99);
      if (roll < 30) begin
        send_item(MODE_PUT, $urandom_range(255));
      end else if (roll < 38) begin
        pick = $urandom_range(3);
        send_item(MODE_PUT, pick == 0 ? CH_CR : pick == 1 ? CH_LF : pick == 2 ? CH_TAB : CH_BS);
      end else if (roll < 42) begin
        repeat ($urandom_range(12, 4)) send_item(MODE_PUT, CH_LF);
      end else if (roll < 44) begin
        repeat ($urandom_range(60, 10)) send_item(MODE_PUT, $urandom_range(126, 32));
      end else if (roll < 70) begin
        pick = $urandom_range(9);
        if (pick < 5) send_item(MODE_READ, $urandom_range(CELLS - 1));
        else if (pick < 8) send_item(MODE_READ, $urandom_range(CELLS - 1, CELLS - 4 * COLS));
        else send_item(MODE_READ, $urandom_range(2047));
      end else if (roll < 90) begin
        send_sequence(1'b0);
      end else begin
        send_sequence(1'b1);
      end
    end
    steady = 1'b0;

    // drop valid and drain outstanding results
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.due_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transfers in (%0d puts, %0d reads), %0d results checked.",
             taken_count, tracker.puts, tracker.reads, tracker.checked);
    $display("Screen scrolled %0d times and was cleared %0d times by escape sequence.",
             tracker.scrolls, tracker.clears);
    if (tracker.mismatches == 0) begin
      $display("** ansi_text_console_renderer: PASSED **");
    end else begin
      $display("** ansi_text_console_renderer: FAILED **");
    end
    $finish;
  end

endmodule
